// ===== rtl/core/trm_pkg.sv =====
package trm_pkg;

    localparam int DataW   = 32;
    localparam int VecW    = DataW + 1;         // difference or sum of two Q16.16 values
    localparam int DotW    = 2 * VecW + 2;      // sum of three VecW x VecW products
    localparam int DenW    = 2 * DotW + 2;      // D, N1 and N2
    localparam int AccW    = 176;               // output numerator, with headroom
    localparam int CfgIdxW = 3;
    localparam int QDepth  = 2;
    localparam int QPtrW   = $clog2(QDepth);
    localparam int QCntW   = $clog2(QDepth + 1);
    localparam int MulCntW = $clog2(DotW + 1);
    localparam int DivCntW = $clog2(AccW + 1);

    typedef enum logic [CfgIdxW-1:0] {
        REG_CAM_X  = 3'd0,
        REG_CAM_Y  = 3'd1,
        REG_CAM_Z  = 3'd2,
        REG_PROJ_X = 3'd3,
        REG_PROJ_Y = 3'd4,
        REG_PROJ_Z = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [DataW-1:0] cam_point_x;
        logic signed [DataW-1:0] cam_point_y;
        logic signed [DataW-1:0] cam_point_z;
        logic signed [DataW-1:0] proj_point_x;
        logic signed [DataW-1:0] proj_point_y;
        logic signed [DataW-1:0] proj_point_z;
    } t_in_req;

    typedef struct packed {
        logic signed [DataW-1:0] object_x;
        logic signed [DataW-1:0] object_y;
        logic signed [DataW-1:0] object_z;
    } t_out_req;

    typedef logic [2:0][VecW-1:0] t_vec;

    typedef struct packed {
        t_vec u;
        t_vec v;
    } t_job;

    typedef struct packed {
        logic start;
        logic long_op;
    } t_mul_ctl;

    typedef struct packed {
        logic done;
        logic neg;
    } t_mul_res;

    typedef struct packed {
        logic done;
        logic big;
    } t_div_res;

endpackage

// ===== rtl/core/two_ray_midpoint_triangulation.sv =====
// channel   direction  handshake                 payload
// request   in         i_valid / o_ready         i_req  (camera and projector ray points)
// result    out        o_valid / i_ready         o_resp (triangulated midpoint)
// config    in         i_cfg_we, i_cfg_idx       i_cfg_data (optical centers)
//
// Throughput is set by the bit-serial multiplier (30 products: 24 short and 6 long)
// and the one-bit-per-cycle divider (3 divisions); the back end works on one request at a time.
// A two-entry queue takes requests back to back while the back end works, until the queue is full.
// A finished result waits in the output register; the next request is computed meanwhile.
// Synchronous active-low reset clears the center registers to zero, empties the queue and idles the back end.
module two_ray_midpoint_triangulation (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [trm_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [trm_pkg::DataW-1:0]    i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  trm_pkg::t_in_req             i_req,
    output logic                         o_valid,
    input  logic                         i_ready,
    output trm_pkg::t_out_req            o_resp
);
    import trm_pkg::*;

    logic  job_valid;
    logic  job_pop;
    t_job  job;
    t_vec  w;
    t_vec  s;

    // front: hold the centers, form ray directions, queue the request
    trm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (i_req),
        .o_job_valid (job_valid),
        .i_job_pop   (job_pop),
        .o_job       (job),
        .o_w         (w),
        .o_s         (s)
    );

    // back: dot products, closest-point solve, rounded midpoint
    trm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_pop   (job_pop),
        .i_job       (job),
        .i_w         (w),
        .i_s         (s),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_out       (o_resp)
    );

endmodule

// ===== rtl/core/trm_front.sv =====
module trm_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [trm_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [trm_pkg::DataW-1:0]    i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  trm_pkg::t_in_req             i_req,
    output logic                         o_job_valid,
    input  logic                         i_job_pop,
    output trm_pkg::t_job                o_job,
    output trm_pkg::t_vec                o_w,
    output trm_pkg::t_vec                o_s
);
    import trm_pkg::*;

    logic signed [DataW-1:0] r_cam  [3];
    logic signed [DataW-1:0] r_proj [3];
    t_job                    r_q [QDepth];
    logic [QPtrW-1:0]        r_wr;
    logic [QPtrW-1:0]        r_rd;
    logic [QCntW-1:0]        r_cnt;

    logic signed [DataW-1:0] pc [3];
    logic signed [DataW-1:0] pp [3];
    t_job                    job_in;
    logic                    push;

    assign pc[0] = i_req.cam_point_x;
    assign pc[1] = i_req.cam_point_y;
    assign pc[2] = i_req.cam_point_z;
    assign pp[0] = i_req.proj_point_x;
    assign pp[1] = i_req.proj_point_y;
    assign pp[2] = i_req.proj_point_z;

    // ray directions and the center terms, all exact in VecW bits
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            job_in.u[k] = VecW'(pc[k]) - VecW'(r_cam[k]);
            job_in.v[k] = VecW'(pp[k]) - VecW'(r_proj[k]);
            o_w[k]      = VecW'(r_cam[k]) - VecW'(r_proj[k]);
            o_s[k]      = VecW'(r_cam[k]) + VecW'(r_proj[k]);
        end
    end

    assign o_ready     = (r_cnt != QCntW'(QDepth));
    assign push        = i_valid && o_ready;
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_cam[k]  <= '0;
                r_proj[k] <= '0;
            end
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CAM_X:  r_cam[0]  <= i_cfg_data;
                    REG_CAM_Y:  r_cam[1]  <= i_cfg_data;
                    REG_CAM_Z:  r_cam[2]  <= i_cfg_data;
                    REG_PROJ_X: r_proj[0] <= i_cfg_data;
                    REG_PROJ_Y: r_proj[1] <= i_cfg_data;
                    REG_PROJ_Z: r_proj[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (push) begin
                r_q[r_wr] <= job_in;
                r_wr      <= r_wr + QPtrW'(1);
            end
            if (i_job_pop) begin
                r_rd <= r_rd + QPtrW'(1);
            end
            if (push && !i_job_pop) begin
                r_cnt <= r_cnt + QCntW'(1);
            end else if (!push && i_job_pop) begin
                r_cnt <= r_cnt - QCntW'(1);
            end
        end
    end

endmodule

// ===== rtl/core/trm_mul.sv =====
module trm_mul (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  trm_pkg::t_mul_ctl                  i_ctl,
    input  logic signed [trm_pkg::AccW-1:0]    i_a,
    input  logic signed [trm_pkg::DotW-1:0]    i_b,
    output trm_pkg::t_mul_res                  o_res,
    output logic [trm_pkg::AccW-1:0]           o_prod
);
    import trm_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic               r_neg;
    logic [MulCntW-1:0] r_cnt;
    logic [AccW-1:0]    r_a;
    logic [DotW-1:0]    r_b;
    logic [AccW-1:0]    r_acc;

    // product of a and the magnitude of b; the caller folds the sign of b into its add
    assign o_prod    = r_acc;
    assign o_res.done = r_done;
    assign o_res.neg  = r_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_ctl.start && r_busy && (r_cnt == MulCntW'(1));
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_a    <= i_a;
                r_b    <= i_b[DotW-1] ? DotW'(-i_b) : DotW'(i_b);
                r_neg  <= i_b[DotW-1];
                r_acc  <= '0;
                r_cnt  <= i_ctl.long_op ? MulCntW'(DotW) : MulCntW'(VecW);
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a   <= r_a << 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt - MulCntW'(1);
                if (r_cnt == MulCntW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== rtl/core/trm_div.sv =====
module trm_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [trm_pkg::AccW-1:0]     i_num,
    input  logic [trm_pkg::DenW:0]       i_den,
    output trm_pkg::t_div_res            o_res,
    output logic [trm_pkg::DataW-1:0]    o_q
);
    import trm_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic               r_big;
    logic [DivCntW-1:0] r_cnt;
    logic [AccW-1:0]    r_num;
    logic [DenW:0]      r_den;
    logic [DenW:0]      r_rem;
    logic [DataW-1:0]   r_q;

    logic [DenW+1:0]    trial;
    logic               fits;

    assign trial = {r_rem, r_num[AccW-1]};
    assign fits  = (trial >= {1'b0, r_den});

    assign o_res.done = r_done;
    assign o_res.big  = r_big;
    assign o_q        = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == DivCntW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
                r_big  <= 1'b0;
                r_cnt  <= DivCntW'(AccW);
            end else if (r_busy) begin
                // one quotient bit per cycle; bits above the low word only flag overflow
                r_rem <= fits ? (DenW+1)'(trial - {1'b0, r_den}) : trial[DenW:0];
                r_q   <= {r_q[DataW-2:0], fits};
                r_big <= r_big | r_q[DataW-1];
                r_num <= r_num << 1;
                r_cnt <= r_cnt - DivCntW'(1);
                if (r_cnt == DivCntW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== rtl/core/trm_back.sv =====
module trm_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    output logic                 o_job_pop,
    input  trm_pkg::t_job        i_job,
    input  trm_pkg::t_vec        i_w,
    input  trm_pkg::t_vec        i_s,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output trm_pkg::t_out_req    o_out
);
    import trm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DOT, S_BIG, S_FIX, S_XMUL, S_ABS, S_DIV, S_OUT
    } t_state;

    localparam logic [2:0] DotA = 3'd0;
    localparam logic [2:0] DotB = 3'd1;
    localparam logic [2:0] DotC = 3'd2;
    localparam logic [2:0] DotD = 3'd3;
    localparam logic [2:0] DotE = 3'd4;
    localparam logic [2:0] BigLast = 3'd5;
    localparam logic [2:0] TermN2  = 3'd2;
    localparam logic [1:0] CompZ   = 2'd2;

    t_state                  r_state;
    logic                    r_wait;
    logic [2:0]              r_j;
    logic [1:0]              r_k;
    t_vec                    r_u;
    t_vec                    r_v;
    logic signed [AccW-1:0]  r_acc;
    logic signed [DotW-1:0]  r_dot [5];
    logic signed [DenW-1:0]  r_big [3];
    logic                    r_xneg;
    logic [DataW-1:0]        r_res [3];
    logic                    r_out_valid;
    t_out_req                r_out;

    logic signed [VecW-1:0]  u_k;
    logic signed [VecW-1:0]  v_k;
    logic signed [VecW-1:0]  w_k;
    logic signed [VecW-1:0]  s_k;
    logic signed [AccW-1:0]  mul_a;
    logic signed [DotW-1:0]  mul_b;
    t_mul_ctl                mul_ctl;
    t_mul_res                mul_res;
    logic [AccW-1:0]         mul_prod;
    logic                    op_sub;
    logic signed [AccW-1:0]  acc_sum;
    logic                    div_start;
    t_div_res                div_res;
    logic [DataW-1:0]        div_q;
    logic [DataW-1:0]        sat_val;

    assign u_k = r_u[r_k];
    assign v_k = r_v[r_k];
    assign w_k = i_w[r_k];
    assign s_k = i_s[r_k];

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        mul_ctl.start   = (r_state == S_DOT || r_state == S_BIG || r_state == S_XMUL)
                          && !r_wait;
        mul_ctl.long_op = 1'b0;
        unique case (r_state)
            S_DOT: begin
                unique case (r_j)
                    DotA: begin mul_a = AccW'(u_k); mul_b = DotW'(u_k); end
                    DotB: begin mul_a = AccW'(u_k); mul_b = DotW'(v_k); end
                    DotC: begin mul_a = AccW'(v_k); mul_b = DotW'(v_k); end
                    DotD: begin mul_a = AccW'(u_k); mul_b = DotW'(w_k); end
                    default: begin mul_a = AccW'(v_k); mul_b = DotW'(w_k); end
                endcase
            end
            S_BIG: begin
                mul_ctl.long_op = 1'b1;
                // D = b*b - c*a, N1 = d*c - b*e, N2 = b*d - a*e
                unique case (r_j)
                    3'd0: begin mul_a = AccW'(r_dot[DotB]); mul_b = r_dot[DotB]; end
                    3'd1: begin mul_a = AccW'(r_dot[DotC]); mul_b = r_dot[DotA]; end
                    3'd2: begin mul_a = AccW'(r_dot[DotD]); mul_b = r_dot[DotC]; end
                    3'd3: begin mul_a = AccW'(r_dot[DotB]); mul_b = r_dot[DotE]; end
                    3'd4: begin mul_a = AccW'(r_dot[DotB]); mul_b = r_dot[DotD]; end
                    default: begin mul_a = AccW'(r_dot[DotA]); mul_b = r_dot[DotE]; end
                endcase
            end
            S_XMUL: begin
                unique case (r_j)
                    3'd0: begin mul_a = AccW'(r_big[0]); mul_b = DotW'(s_k); end
                    3'd1: begin mul_a = AccW'(r_big[1]); mul_b = DotW'(u_k); end
                    default: begin mul_a = AccW'(r_big[2]); mul_b = DotW'(v_k); end
                endcase
            end
            default: ;
        endcase
    end

    assign op_sub  = (r_state == S_BIG) && r_j[0];
    assign acc_sum = (op_sub ^ mul_res.neg) ? r_acc - $signed(mul_prod)
                                            : r_acc + $signed(mul_prod);

    assign div_start = (r_state == S_DIV) && !r_wait;

    // clamp the rounded magnitude and restore the sign
    always_comb begin
        if (r_xneg) begin
            sat_val = (div_res.big || div_q > 32'h8000_0000) ? 32'h8000_0000 : -div_q;
        end else begin
            sat_val = (div_res.big || div_q[DataW-1]) ? 32'h7FFF_FFFF : div_q;
        end
    end

    trm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mul_ctl),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_res   (mul_res),
        .o_prod  (mul_prod)
    );

    trm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (AccW'(r_acc + AccW'(r_big[0]))),
        .i_den   ({r_big[0], 1'b0}),
        .o_res   (div_res),
        .o_q     (div_q)
    );

    assign o_job_pop   = (r_state == S_IDLE) && i_job_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one replaces it this cycle
            if (r_out_valid && i_out_ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_u     <= i_job.u;
                        r_v     <= i_job.v;
                        r_j     <= '0;
                        r_k     <= '0;
                        r_acc   <= '0;
                        r_wait  <= 1'b0;
                        r_state <= S_DOT;
                    end
                end
                S_DOT: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_res.done) begin
                        r_wait <= 1'b0;
                        r_acc  <= (r_k == CompZ) ? '0 : acc_sum;
                        if (r_k == CompZ) begin
                            r_dot[r_j] <= acc_sum[DotW-1:0];
                            r_k        <= '0;
                            if (r_j == DotE) begin
                                r_j     <= '0;
                                r_state <= S_BIG;
                            end else begin
                                r_j <= r_j + 3'd1;
                            end
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end
                end
                S_BIG: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_res.done) begin
                        r_wait <= 1'b0;
                        r_acc  <= r_j[0] ? '0 : acc_sum;
                        if (r_j[0]) begin
                            r_big[r_j[2:1]] <= acc_sum[DenW-1:0];
                        end
                        if (r_j == BigLast) begin
                            r_state <= S_FIX;
                        end else begin
                            r_j <= r_j + 3'd1;
                        end
                    end
                end
                S_FIX: begin
                    // parallel rays: zero both ray parameters; else make D positive
                    if (r_big[0] == '0) begin
                        r_big[0] <= DenW'(1);
                        r_big[1] <= '0;
                        r_big[2] <= '0;
                    end else if (r_big[0][DenW-1]) begin
                        r_big[0] <= -r_big[0];
                        r_big[1] <= -r_big[1];
                        r_big[2] <= -r_big[2];
                    end
                    r_j     <= '0;
                    r_k     <= '0;
                    r_acc   <= '0;
                    r_state <= S_XMUL;
                end
                S_XMUL: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_res.done) begin
                        r_wait <= 1'b0;
                        r_acc  <= acc_sum;
                        if (r_j == TermN2) begin
                            r_state <= S_ABS;
                        end else begin
                            r_j <= r_j + 3'd1;
                        end
                    end
                end
                S_ABS: begin
                    r_xneg  <= r_acc[AccW-1];
                    r_acc   <= r_acc[AccW-1] ? -r_acc : r_acc;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (div_res.done) begin
                        r_wait     <= 1'b0;
                        r_res[r_k] <= sat_val;
                        if (r_k == CompZ) begin
                            r_state <= S_OUT;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_j     <= '0;
                            r_acc   <= '0;
                            r_state <= S_XMUL;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid    <= 1'b1;
                        r_out.object_x <= r_res[0];
                        r_out.object_y <= r_res[1];
                        r_out.object_z <= r_res[2];
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_mul_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_res.done |-> r_wait && (r_state == S_DOT || r_state == S_BIG ||
                                    r_state == S_XMUL))
        else $error("multiplier finished with no product pending");

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> r_wait && r_state == S_DIV)
        else $error("divider finished with no quotient pending");

    a_den_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XMUL || r_state == S_ABS || r_state == S_DIV)
        |-> (r_big[0] != '0) && !r_big[0][DenW-1])
        else $error("denominator not positive after fixup");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    import trm_pkg::*;

    // Indexes past the register list; writes there must be dropped.
    localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;
    localparam int StallMax  = 11;
    localparam int IdleLimit = 40000;
    localparam int RandItems = 1430;
    localparam int NumPhases = 6;

    typedef struct {
        t_in_req  req;
        bit       has_exp;
        t_out_req exp;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [DataW-1:0]    i_cfg_data;
    logic                i_valid;
    logic                o_ready;
    t_in_req             i_req;
    logic                o_valid;
    logic                i_ready;
    t_out_req            o_resp;

    // Mirror of the optical-center registers: camera x,y,z then projector x,y,z.
    logic signed [DataW-1:0] center_regs [6];

    t_out_req midpoint_q [$];
    bit       row_has_exp;
    t_out_req row_exp;
    int       err_count;
    int       req_count;
    int       resp_count;
    int       idle_cycles;
    bit       stim_done;

    two_ray_midpoint_triangulation u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_resp     (o_resp)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Closest points on the two lines, midpoint rounded to nearest (ties away
    // from zero) and clamped to 32 bits. 256-bit signed math never overflows.
    function automatic t_out_req triangulate(t_in_req r);
        logic signed [255:0] pc [3];
        logic signed [255:0] pp [3];
        logic signed [255:0] oc [3];
        logic signed [255:0] op [3];
        logic signed [255:0] u [3];
        logic signed [255:0] v [3];
        logic signed [255:0] w [3];
        logic signed [255:0] a, b, c, d, e, den, n1, n2, x;
        logic [255:0]        mag, twice, q, rem;
        logic [DataW-1:0]    res [3];
        t_out_req            o;
        pc[0] = r.cam_point_x;  pc[1] = r.cam_point_y;  pc[2] = r.cam_point_z;
        pp[0] = r.proj_point_x; pp[1] = r.proj_point_y; pp[2] = r.proj_point_z;
        for (int k = 0; k < 3; k++) begin
            oc[k] = center_regs[k];
            op[k] = center_regs[k+3];
            w[k]  = oc[k] - op[k];
            u[k]  = pc[k] - oc[k];
            v[k]  = pp[k] - op[k];
        end
        a = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
        b = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
        c = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
        d = u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
        e = v[0]*w[0] + v[1]*w[1] + v[2]*w[2];
        den = b*b - c*a;
        n1  = d*c - b*e;
        n2  = b*d - a*e;
        // Parallel or degenerate rays: both ray parameters drop to zero.
        if (den == 0) begin
            n1  = 0;
            n2  = 0;
            den = 1;
        end
        if (den < 0) begin
            den = -den;
            n1  = -n1;
            n2  = -n2;
        end
        twice = den + den;
        for (int k = 0; k < 3; k++) begin
            x   = (oc[k] + op[k]) * den + n1 * u[k] + n2 * v[k];
            mag = (x < 0) ? -x : x;
            q   = mag / twice;
            rem = mag % twice;
            if ((rem << 1) >= twice) q = q + 1;
            if (x < 0) res[k] = (q > 256'h8000_0000) ? 32'h8000_0000 : -q[DataW-1:0];
            else       res[k] = (q > 256'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[DataW-1:0];
        end
        o.object_x = res[0];
        o.object_y = res[1];
        o.object_z = res[2];
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [DataW-1:0] got, logic [DataW-1:0] want);
        err_count++;
        $display("MISMATCH result %0d %s: got %h want %h", resp_count, what, got, want);
    endtask

    // Bias random coordinates toward extremes and small values.
    function automatic logic [DataW-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            3:       return 32'($signed($urandom_range(0, 65536)) - 32768);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_req rand_req();
        t_in_req r;
        logic [DataW-1:0] s;
        r.cam_point_x  = rand_coord();
        r.cam_point_y  = rand_coord();
        r.cam_point_z  = rand_coord();
        r.proj_point_x = rand_coord();
        r.proj_point_y = rand_coord();
        r.proj_point_z = rand_coord();
        case ($urandom_range(0, 9))
            0: begin // parallel rays: projector direction is the camera direction scaled by 1 to 3
                s = $urandom_range(1, 3);
                r.proj_point_x = center_regs[3] + s * (r.cam_point_x - center_regs[0]);
                r.proj_point_y = center_regs[4] + s * (r.cam_point_y - center_regs[1]);
                r.proj_point_z = center_regs[5] + s * (r.cam_point_z - center_regs[2]);
            end
            1: begin // zero-length camera ray
                r.cam_point_x = center_regs[0];
                r.cam_point_y = center_regs[1];
                r.cam_point_z = center_regs[2];
            end
            2: begin // zero-length projector ray
                r.proj_point_x = center_regs[3];
                r.proj_point_y = center_regs[4];
                r.proj_point_z = center_regs[5];
            end
            default: ;
        endcase
        return r;
    endfunction

    // Hold off until the back end has drained.
    // Wait for a clock edge first so the monitor has logged the last accepted request.
    task automatic wait_idle();
        @(posedge i_clk);
        while (midpoint_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_centers(logic [DataW-1:0] vals [6]);
        wait_idle();
        for (int k = 0; k < 6; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_reg_idx'(k);
            i_cfg_data <= vals[k];
            center_regs[k] = vals[k];
            @(posedge i_clk);
        end
        // Out-of-range indexes: the block must ignore these.
        i_cfg_idx  <= REG_SPARE_LO;
        i_cfg_data <= $urandom;
        @(posedge i_clk);
        i_cfg_idx  <= REG_SPARE_HI;
        i_cfg_data <= $urandom;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Present one request after a random gap, hold it until accepted.
    task automatic send_req(t_in_req r, bit has_exp, t_out_req e);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, StallMax);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req       <= r;
        row_has_exp <= has_exp;
        row_exp     <= e;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Receiver: random stalls, with stretches of steady readiness.
    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, StallMax);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Monitor both channels on the sampled values of each edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            req_count++;
            midpoint_q.insert(midpoint_q.size(), row_has_exp ? row_exp : triangulate(i_req));
        end
        if (i_rst_n && o_valid && i_ready) begin
            t_out_req want;
            if (midpoint_q.size() == 0) begin
                err_count++;
                $display("MISMATCH result %0d arrived with nothing expected", resp_count);
            end else begin
                want = midpoint_q.pop_front();
                if (o_resp.object_x !== want.object_x)
                    report_mismatch("object_x", o_resp.object_x, want.object_x);
                if (o_resp.object_y !== want.object_y)
                    report_mismatch("object_y", o_resp.object_y, want.object_y);
                if (o_resp.object_z !== want.object_z)
                    report_mismatch("object_z", o_resp.object_z, want.object_z);
            end
            resp_count++;
        end
    end

    // Watchdog: too long with no handshake on either side ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit && (!stim_done || midpoint_q.size() != 0)) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_stim_row        rows [$];
        t_stim_row        row;
        t_out_req         zero_out;
        logic [DataW-1:0] vals [6];
        int               per_phase;

        err_count   = 0;
        req_count   = 0;
        resp_count  = 0;
        idle_cycles = 0;
        stim_done   = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_CAM_X;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_req       = '0;
        row_has_exp = 1'b0;
        row_exp     = '0;
        zero_out    = '0;
        for (int k = 0; k < 6; k++) center_regs[k] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With both centers at the origin after reset, w is zero, so every
        // request lands on the origin, degenerate or not.
        row.has_exp = 1'b1;
        row.exp     = zero_out;
        row.req = '0;                                   rows.insert(rows.size(), row);
        row.req = {6{32'h7FFF_FFFF}};                   rows.insert(rows.size(), row);
        row.req = {6{32'h8000_0000}};                   rows.insert(rows.size(), row);
        row.req = {{3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}};
        rows.insert(rows.size(), row);
        row.req = {32'h0001_0000, 64'h0, 32'h0, 32'h0001_0000, 32'h0};
        rows.insert(rows.size(), row);
        row.req = {32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF};
        rows.insert(rows.size(), row);
        foreach (rows[i]) send_req(rows[i].req, rows[i].has_exp, rows[i].exp);
        i_valid <= 1'b0;

        // Extreme centers, then degenerate and parallel rays against the predictor.
        vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        write_centers(vals);
        rows.delete();
        row.has_exp = 1'b0;
        row.req = {vals[0], vals[1], vals[2], vals[3], vals[4], vals[5]};
        rows.insert(rows.size(), row);
        row.req = {6{32'h7FFF_FFFF}};                   rows.insert(rows.size(), row);
        row.req = {6{32'h8000_0000}};                   rows.insert(rows.size(), row);
        row.req = {vals[3], vals[4], vals[5], vals[0], vals[1], vals[2]};
        rows.insert(rows.size(), row);
        row.req = {32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0, 32'h0};
        rows.insert(rows.size(), row);
        foreach (rows[i]) send_req(rows[i].req, 1'b0, zero_out);
        i_valid <= 1'b0;

        per_phase = RandItems / NumPhases;
        for (int ph = 0; ph < NumPhases; ph++) begin
            case (ph)
                0: vals = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
                1: vals = '{32'h0, 32'h0, 32'h0, 32'h0064_0000, 32'h0, 32'h0};
                2: vals = '{32'hFF9C_0000, 32'h0000_8000, 32'h0,
                            32'h0064_0000, 32'h0, 32'h0001_0000};
                default: foreach (vals[k]) vals[k] = rand_coord();
            endcase
            write_centers(vals);
            for (int n = 0; n < per_phase; n++) begin
                // Drain the back end fully once before going on.
                if (ph == 3 && n == per_phase / 2) begin
                    i_valid <= 1'b0;
                    wait_idle();
                end
                send_req(rand_req(), 1'b0, zero_out);
            end
            i_valid <= 1'b0;
        end

        stim_done = 1'b1;
        wait_idle();
        repeat (2000) @(posedge i_clk);
        $display("covered %0d requests and %0d results over %0d center settings,",
                 req_count, resp_count, NumPhases + 2);
        $display("including extreme, degenerate and parallel rays");
        if (err_count == 0 && midpoint_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches, %0d results missing", err_count, midpoint_q.size());
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ===== two_ray_midpoint_triangulation.f =====
rtl/core/trm_pkg.sv
rtl/core/trm_front.sv
rtl/core/trm_mul.sv
rtl/core/trm_div.sv
rtl/core/trm_back.sv
rtl/core/two_ray_midpoint_triangulation.sv
sim/tb_top.sv
